FILE: hdl/ktx_pkg.sv
`timescale 1ns / 1ps

package ktx_pkg;

  localparam int MAX_LEVELS = 16;
  localparam int DIM_BITS   = 16;
  localparam int LVL_W      = $clog2(MAX_LEVELS + 1);
  localparam int ROW_W      = DIM_BITS + 2;
  localparam int PROD_W     = ROW_W + DIM_BITS;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       new_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  pixel_byte;
    logic [3:0]  level;
    logic [2:0]  pixel_format;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [4:0]  mip_count;
    logic [5:0]  image_depth;
    logic [3:0]  error_code;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [ROW_W-1:0]  a;
    logic [DIM_BITS-1:0] b;
  } mul_req_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_ID, PH_ENDIAN, PH_HDR, PH_KV, PH_SIZE, PH_SKIP, PH_DATA, PH_PAD
  } phase_t;

  typedef enum logic [2:0] {
    SQ_READY, SQ_EXEC, SQ_MUL, SQ_MULW, SQ_EMIT
  } seq_t;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  localparam logic [3:0] ERR_ID         = 4'd1;
  localparam logic [3:0] ERR_ENDIAN     = 4'd2;
  localparam logic [3:0] ERR_3D         = 4'd3;
  localparam logic [3:0] ERR_ARRAY      = 4'd4;
  localparam logic [3:0] ERR_CUBE       = 4'd5;
  localparam logic [3:0] ERR_ZERO_WIDTH = 4'd6;
  localparam logic [3:0] ERR_COMP_FMT   = 4'd7;
  localparam logic [3:0] ERR_UNCOMP_FMT = 4'd8;
  localparam logic [3:0] ERR_SIZE_SMALL = 4'd9;
  localparam logic [3:0] ERR_TOO_LARGE  = 4'd10;

  localparam logic CFG_GRAY_AS_ALPHA = 1'b0;
  localparam logic CFG_MIP_SKIP      = 1'b1;

  localparam logic [31:0] ENDIAN_NATIVE  = 32'h04030201;
  localparam logic [31:0] ENDIAN_SWAPPED = 32'h01020304;
  localparam logic [31:0] FMT_DXT1       = 32'h83F0;
  localparam logic [31:0] FMT_DXT5       = 32'h83F3;
  localparam logic [31:0] FMT_ALPHA      = 32'h1906;
  localparam logic [31:0] FMT_RGB        = 32'h1907;
  localparam logic [31:0] FMT_RGBA       = 32'h1908;
  localparam logic [31:0] FMT_LUM        = 32'h1909;
  localparam logic [31:0] FMT_LUM_ALPHA  = 32'h190A;

  localparam logic [2:0] PF_RGBA      = 3'd0;
  localparam logic [2:0] PF_LUM       = 3'd1;
  localparam logic [2:0] PF_ALPHA     = 3'd2;
  localparam logic [2:0] PF_LUM_ALPHA = 3'd3;

endpackage

FILE: hdl/ktx_mul.sv
`timescale 1ns / 1ps

module ktx_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ktx_pkg::mul_req_t             req,
  output logic                          done,
  output logic [ktx_pkg::PROD_W-1:0]    product
);

  localparam int CW = $clog2(ktx_pkg::DIM_BITS + 1);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [ktx_pkg::PROD_W-1:0]    a_r, a_nxt;
  logic [ktx_pkg::PROD_W-1:0]    acc_r, acc_nxt;
  logic [ktx_pkg::DIM_BITS-1:0]  b_r, b_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(ktx_pkg::DIM_BITS);
      a_nxt    = ktx_pkg::PROD_W'(req.a);
      b_nxt    = req.b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_nxt = acc_r + a_r;
      end
      a_nxt   = a_r << 1;
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

FILE: hdl/ktx1_texture_stream_parser.sv
`timescale 1ns / 1ps

// KTX1 stream parser. Bytes enter one transaction at a time, starting at identifier byte 4,
// and the block takes the next byte only after all results of the current one have been
// loaded into the output register. The size word of an uncompressed level is also checked by
// the shift-add multiplier, which compares the image size against row stride times height,
// one height bit per cycle.
// Configuration writes are always accepted and must only be issued while the block is idle.

module ktx1_texture_stream_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ktx_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ktx_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data
);

  localparam int DB = ktx_pkg::DIM_BITS;
  localparam int RW = ktx_pkg::ROW_W;
  localparam int LW = ktx_pkg::LVL_W;

  function automatic ktx_pkg::out_item_t mk(
    input logic [1:0] kind, input logic [7:0] px, input logic [3:0] lvl,
    input logic [2:0] fmt, input logic [15:0] w, input logic [15:0] h,
    input logic [4:0] mips, input logic [5:0] depth, input logic [3:0] err);
    ktx_pkg::out_item_t r;
    r.kind = kind; r.pixel_byte = px; r.level = lvl; r.pixel_format = fmt;
    r.image_width = w; r.image_height = h; r.mip_count = mips;
    r.image_depth = depth; r.error_code = err; r.last = 1'b0;
    return r;
  endfunction

  ktx_pkg::seq_t       seq_r, seq_nxt;
  ktx_pkg::phase_t     phase_r, phase_nxt, ph_c;
  logic [5:0]          bc_r, bc_nxt, bc_c, bc_inc;
  logic [31:0]         ws_r, ws_nxt, w_new, w_val;
  logic                swap_r, swap_nxt;
  logic                tzero_r, tzero_nxt, fzero_r, fzero_nxt, comp_c;
  logic [31:0]         ifmt_r, ifmt_nxt, bfmt_r, bfmt_nxt;
  logic [DB-1:0]       cur_w_r, cur_w_nxt, cur_h_r, cur_h_nxt;
  logic [LW-1:0]       levels_r, levels_nxt;
  logic [31:0]         kv_r, kv_nxt, img_r, img_nxt;
  logic [3:0]          lidx_r, lidx_nxt;
  logic [RW-1:0]       rowpos_r, rowpos_nxt, rb_r, rb_nxt, stride_r, stride_nxt;
  logic [DB-1:0]       rowidx_r, rowidx_nxt, lh_r, lh_nxt;
  logic [1:0]          rgb_r, rgb_nxt, pad_r, pad_nxt;
  logic [3:0]          skip_r, skip_nxt;
  logic                f3d_r, f3d_nxt, farr_r, farr_nxt, fcube_r, fcube_nxt;
  logic                flarge_r, flarge_nxt;
  logic                gray_r;
  logic [3:0]          mipskip_r;
  logic [7:0]          byte_r, byte_nxt;
  logic                newf_r, newf_nxt;
  ktx_pkg::out_item_t  res_r [3];
  ktx_pkg::out_item_t  res_nxt [3];
  logic [1:0]          cnt_r, cnt_nxt, idx_r, idx_nxt, n;
  logic                out_valid_r, out_valid_nxt;
  ktx_pkg::out_item_t  out_data_r, out_data_nxt;
  logic                out_free;
  logic                do_lend, do_hdr;
  logic [3:0]          err_c, hidx;
  logic [DB-1:0]       m_c, mm1, lw_c, lh_c;
  logic [4:0]          e_c, s_c;
  logic [RW-1:0]       rb_c, rp_inc;
  logic [2:0]          fmt_c;
  logic [5:0]          depth_c;
  logic [LW-1:0]       lv_c;
  logic [31:0]         wv_lvl;
  ktx_pkg::mul_req_t   mreq;
  logic                mdone;
  logic [ktx_pkg::PROD_W-1:0] mprod;

  ktx_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mreq),
    .done    (mdone),
    .product (mprod)
  );

  assign in_stall  = (seq_r != ktx_pkg::SQ_READY);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= ktx_pkg::SQ_READY;
      phase_r     <= ktx_pkg::PH_IDLE;
      bc_r        <= '0;
      ws_r        <= '0;
      swap_r      <= 1'b0;
      tzero_r     <= 1'b0;
      fzero_r     <= 1'b0;
      ifmt_r      <= '0;
      bfmt_r      <= '0;
      cur_w_r     <= '0;
      cur_h_r     <= '0;
      levels_r    <= '0;
      kv_r        <= '0;
      img_r       <= '0;
      lidx_r      <= '0;
      rowpos_r    <= '0;
      rowidx_r    <= '0;
      rgb_r       <= '0;
      pad_r       <= '0;
      skip_r      <= '0;
      f3d_r       <= 1'b0;
      farr_r      <= 1'b0;
      fcube_r     <= 1'b0;
      flarge_r    <= 1'b0;
      gray_r      <= 1'b0;
      mipskip_r   <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      seq_r       <= seq_nxt;
      phase_r     <= phase_nxt;
      bc_r        <= bc_nxt;
      ws_r        <= ws_nxt;
      swap_r      <= swap_nxt;
      tzero_r     <= tzero_nxt;
      fzero_r     <= fzero_nxt;
      ifmt_r      <= ifmt_nxt;
      bfmt_r      <= bfmt_nxt;
      cur_w_r     <= cur_w_nxt;
      cur_h_r     <= cur_h_nxt;
      levels_r    <= levels_nxt;
      kv_r        <= kv_nxt;
      img_r       <= img_nxt;
      lidx_r      <= lidx_nxt;
      rowpos_r    <= rowpos_nxt;
      rowidx_r    <= rowidx_nxt;
      rgb_r       <= rgb_nxt;
      pad_r       <= pad_nxt;
      skip_r      <= skip_nxt;
      f3d_r       <= f3d_nxt;
      farr_r      <= farr_nxt;
      fcube_r     <= fcube_nxt;
      flarge_r    <= flarge_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ktx_pkg::CFG_GRAY_AS_ALPHA: gray_r <= cfg_data[0];
          ktx_pkg::CFG_MIP_SKIP:      mipskip_r <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
    rb_r       <= rb_nxt;
    stride_r   <= stride_nxt;
    lh_r       <= lh_nxt;
    byte_r     <= byte_nxt;
    newf_r     <= newf_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    seq_nxt = seq_r; phase_nxt = phase_r; bc_nxt = bc_r; ws_nxt = ws_r;
    swap_nxt = swap_r; tzero_nxt = tzero_r; fzero_nxt = fzero_r;
    ifmt_nxt = ifmt_r; bfmt_nxt = bfmt_r; cur_w_nxt = cur_w_r; cur_h_nxt = cur_h_r;
    levels_nxt = levels_r; kv_nxt = kv_r; img_nxt = img_r; lidx_nxt = lidx_r;
    rowpos_nxt = rowpos_r; rowidx_nxt = rowidx_r; rgb_nxt = rgb_r; pad_nxt = pad_r;
    skip_nxt = skip_r; f3d_nxt = f3d_r; farr_nxt = farr_r; fcube_nxt = fcube_r;
    flarge_nxt = flarge_r; rb_nxt = rb_r; stride_nxt = stride_r; lh_nxt = lh_r;
    byte_nxt = byte_r; newf_nxt = newf_r; res_nxt = res_r; cnt_nxt = cnt_r;
    idx_nxt = idx_r; out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    mreq.start = 1'b0; mreq.a = stride_r; mreq.b = lh_r;
    n = 2'd0; do_lend = 1'b0; do_hdr = 1'b0; err_c = '0;
    ph_c = phase_r; bc_c = bc_r; bc_inc = '0; w_new = '0; w_val = '0; hidx = '0;
    m_c = '0; mm1 = '0; e_c = '0; s_c = '0; lw_c = '0; lh_c = '0; rb_c = '0;
    rp_inc = '0; fmt_c = '0; depth_c = '0; lv_c = '0; wv_lvl = '0;
    comp_c = tzero_r && fzero_r;

    case (seq_r)
      ktx_pkg::SQ_READY: begin
        if (in_valid) begin
          byte_nxt = in_data.in_byte;
          newf_nxt = in_data.new_file;
          seq_nxt  = ktx_pkg::SQ_EXEC;
        end
      end
      ktx_pkg::SQ_EXEC: begin
        seq_nxt = ktx_pkg::SQ_READY;
        if (newf_r) begin
          ph_c = ktx_pkg::PH_ID; phase_nxt = ktx_pkg::PH_ID; bc_c = '0; bc_nxt = '0;
          ws_nxt = '0; f3d_nxt = 1'b0; farr_nxt = 1'b0; fcube_nxt = 1'b0;
          flarge_nxt = 1'b0; swap_nxt = 1'b0; skip_nxt = '0; lidx_nxt = '0;
        end
        bc_inc = bc_c + 6'd1;
        w_new  = {byte_r, (newf_r ? 24'd0 : ws_r[31:8])};
        w_val  = swap_nxt ? {w_new[7:0], w_new[15:8], w_new[23:16], w_new[31:24]} : w_new;
        case (ph_c)
          ktx_pkg::PH_ID: begin
            case (bc_c[2:0])
              3'd0: err_c = (byte_r != 8'h20) ? ktx_pkg::ERR_ID : 4'd0;
              3'd1: err_c = (byte_r != 8'h31) ? ktx_pkg::ERR_ID : 4'd0;
              3'd2: err_c = (byte_r != 8'h31) ? ktx_pkg::ERR_ID : 4'd0;
              3'd3: err_c = (byte_r != 8'hBB) ? ktx_pkg::ERR_ID : 4'd0;
              3'd4: err_c = (byte_r != 8'h0D) ? ktx_pkg::ERR_ID : 4'd0;
              3'd5: err_c = (byte_r != 8'h0A) ? ktx_pkg::ERR_ID : 4'd0;
              3'd6: err_c = (byte_r != 8'h1A) ? ktx_pkg::ERR_ID : 4'd0;
              default: err_c = (byte_r != 8'h0A) ? ktx_pkg::ERR_ID : 4'd0;
            endcase
            bc_nxt = bc_inc;
            if (err_c == 4'd0 && bc_inc >= 6'd8) begin
              phase_nxt = ktx_pkg::PH_ENDIAN; bc_nxt = '0; ws_nxt = '0;
            end
          end
          ktx_pkg::PH_ENDIAN, ktx_pkg::PH_HDR, ktx_pkg::PH_SIZE: begin
            ws_nxt = w_new;
            bc_nxt = bc_inc;
            if (bc_inc[1:0] == 2'd0) begin
              if (ph_c == ktx_pkg::PH_ENDIAN) begin
                if (w_new == ktx_pkg::ENDIAN_NATIVE) swap_nxt = 1'b0;
                else if (w_new == ktx_pkg::ENDIAN_SWAPPED) swap_nxt = 1'b1;
                else err_c = ktx_pkg::ERR_ENDIAN;
                phase_nxt = ktx_pkg::PH_HDR; bc_nxt = '0; ws_nxt = '0;
              end else if (ph_c == ktx_pkg::PH_HDR) begin
                hidx = bc_inc[5:2] - 4'd1;
                case (hidx)
                  4'd0: tzero_nxt = (w_val == 32'd0);
                  4'd2: fzero_nxt = (w_val == 32'd0);
                  4'd3: ifmt_nxt = w_val;
                  4'd4: bfmt_nxt = w_val;
                  4'd5: begin
                    if ((w_val >> DB) != 32'd0) flarge_nxt = 1'b1;
                    cur_w_nxt = w_val[DB-1:0];
                  end
                  4'd6: begin
                    if ((w_val >> DB) != 32'd0) flarge_nxt = 1'b1;
                    cur_h_nxt = (w_val == 32'd0) ? DB'(1) : w_val[DB-1:0];
                  end
                  4'd7: if (w_val > 32'd1) f3d_nxt = 1'b1;
                  4'd8: if (w_val > 32'd1) farr_nxt = 1'b1;
                  4'd9: if (w_val > 32'd1) fcube_nxt = 1'b1;
                  4'd10: begin
                    if (w_val == 32'd0) levels_nxt = LW'(1);
                    else if (w_val > 32'(ktx_pkg::MAX_LEVELS))
                      levels_nxt = LW'(ktx_pkg::MAX_LEVELS);
                    else levels_nxt = w_val[LW-1:0];
                  end
                  4'd11: begin
                    if (f3d_r) err_c = ktx_pkg::ERR_3D;
                    else if (farr_r) err_c = ktx_pkg::ERR_ARRAY;
                    else if (fcube_r) err_c = ktx_pkg::ERR_CUBE;
                    else if (!flarge_r && cur_w_r == '0) err_c = ktx_pkg::ERR_ZERO_WIDTH;
                    else if (flarge_r) err_c = ktx_pkg::ERR_TOO_LARGE;
                    else if (comp_c) begin
                      if (ifmt_r < ktx_pkg::FMT_DXT1 || ifmt_r > ktx_pkg::FMT_DXT5)
                        err_c = ktx_pkg::ERR_COMP_FMT;
                    end else if (bfmt_r < ktx_pkg::FMT_ALPHA ||
                                 bfmt_r > ktx_pkg::FMT_LUM_ALPHA)
                      err_c = ktx_pkg::ERR_UNCOMP_FMT;
                    if (err_c == 4'd0) begin
                      skip_nxt = '0;
                      lidx_nxt = '0;
                      m_c = (cur_w_r < cur_h_r) ? cur_w_r : cur_h_r;
                      mm1 = m_c - DB'(1);
                      for (int i = 0; i < DB; i++) begin
                        if (mm1[i]) e_c = 5'(i + 1);
                      end
                      if (m_c <= DB'(1)) e_c = '0;
                      if (comp_c && levels_r > LW'(1) && mipskip_r != 4'd0 && e_c > 5'd2) begin
                        s_c = {1'b0, mipskip_r};
                        if (s_c > e_c - 5'd2) s_c = e_c - 5'd2;
                        if (s_c > 5'(levels_r) - 5'd1) s_c = 5'(levels_r) - 5'd1;
                        cur_w_nxt = cur_w_r >> s_c;
                        if (cur_w_nxt == '0) cur_w_nxt = DB'(1);
                        cur_h_nxt = cur_h_r >> s_c;
                        if (cur_h_nxt == '0) cur_h_nxt = DB'(1);
                        levels_nxt = levels_r - LW'(s_c);
                        skip_nxt = s_c[3:0];
                      end
                      kv_nxt = w_val;
                      if (w_val == 32'd0) do_hdr = 1'b1;
                      else phase_nxt = ktx_pkg::PH_KV;
                    end
                  end
                  default: ;
                endcase
              end else begin
                wv_lvl = w_val;
                img_nxt = wv_lvl;
                pad_nxt = 2'(32'd0 - wv_lvl);
                rowpos_nxt = '0; rowidx_nxt = '0; rgb_nxt = '0;
                lw_c = cur_w_r >> lidx_r;
                if (lw_c == '0) lw_c = DB'(1);
                lh_c = cur_h_r >> lidx_r;
                if (lh_c == '0) lh_c = DB'(1);
                case (bfmt_r)
                  ktx_pkg::FMT_RGBA:      rb_c = {lw_c, 2'b00};
                  ktx_pkg::FMT_RGB:       rb_c = {lw_c, 2'b00} - RW'(lw_c);
                  ktx_pkg::FMT_LUM_ALPHA: rb_c = {1'b0, lw_c, 1'b0};
                  default:                rb_c = RW'(lw_c);
                endcase
                rb_nxt = rb_c;
                stride_nxt = (rb_c + RW'(3)) & ~RW'(3);
                lh_nxt = lh_c;
                if (skip_r != 4'd0) begin
                  phase_nxt = ktx_pkg::PH_SKIP;
                  if (wv_lvl == 32'd0) do_lend = 1'b1;
                end else if (comp_c) begin
                  phase_nxt = ktx_pkg::PH_DATA;
                  if (wv_lvl == 32'd0) do_lend = 1'b1;
                end else begin
                  seq_nxt = ktx_pkg::SQ_MUL;
                end
              end
            end
          end
          ktx_pkg::PH_KV: begin
            kv_nxt = kv_r - 32'd1;
            if (kv_nxt == 32'd0) do_hdr = 1'b1;
          end
          ktx_pkg::PH_SKIP, ktx_pkg::PH_DATA: begin
            if (ph_c == ktx_pkg::PH_DATA) begin
              if (comp_c) begin
                res_nxt[n] = mk(ktx_pkg::KIND_PIXEL, byte_r, lidx_r, '0, '0, '0, '0, '0, '0);
                n = n + 2'd1;
              end else begin
                if (rowidx_r < lh_r && rowpos_r < rb_r) begin
                  res_nxt[n] = mk(ktx_pkg::KIND_PIXEL, byte_r, lidx_r, '0, '0, '0, '0, '0,
                                  '0);
                  n = n + 2'd1;
                  if (bfmt_r == ktx_pkg::FMT_RGB) begin
                    if (rgb_r >= 2'd2) begin
                      res_nxt[n] = mk(ktx_pkg::KIND_PIXEL, 8'hFF, lidx_r, '0, '0, '0, '0,
                                      '0, '0);
                      n = n + 2'd1;
                      rgb_nxt = '0;
                    end else begin
                      rgb_nxt = rgb_r + 2'd1;
                    end
                  end
                end
                rp_inc = rowpos_r + RW'(1);
                rowpos_nxt = rp_inc;
                if (rp_inc >= stride_r) begin
                  rowpos_nxt = '0; rgb_nxt = '0;
                  if (rowidx_r < lh_r) rowidx_nxt = rowidx_r + DB'(1);
                end
              end
            end
            img_nxt = img_r - 32'd1;
            if (img_nxt == 32'd0) begin
              if (pad_r != 2'd0) phase_nxt = ktx_pkg::PH_PAD;
              else do_lend = 1'b1;
            end
          end
          ktx_pkg::PH_PAD: begin
            pad_nxt = pad_r - 2'd1;
            if (pad_nxt == 2'd0) do_lend = 1'b1;
          end
          default: ;
        endcase

        if (err_c != 4'd0) begin
          res_nxt[n] = mk(ktx_pkg::KIND_ERROR, '0, '0, '0, '0, '0, '0, '0, err_c);
          n = n + 2'd1;
          phase_nxt = ktx_pkg::PH_IDLE;
        end

        if (do_hdr) begin
          if (comp_c) begin
            fmt_c = {1'b1, ifmt_r[1:0]};
            depth_c = (ifmt_r == ktx_pkg::FMT_DXT1) ? 6'd24 : 6'd32;
          end else begin
            case (bfmt_r)
              ktx_pkg::FMT_RGBA:  begin fmt_c = ktx_pkg::PF_RGBA; depth_c = 6'd32; end
              ktx_pkg::FMT_RGB:   begin fmt_c = ktx_pkg::PF_RGBA; depth_c = 6'd24; end
              ktx_pkg::FMT_LUM: begin
                fmt_c = gray_r ? ktx_pkg::PF_ALPHA : ktx_pkg::PF_LUM; depth_c = 6'd8;
              end
              ktx_pkg::FMT_ALPHA: begin fmt_c = ktx_pkg::PF_ALPHA; depth_c = 6'd8; end
              default: begin fmt_c = ktx_pkg::PF_LUM_ALPHA; depth_c = 6'd16; end
            endcase
          end
          res_nxt[n] = mk(ktx_pkg::KIND_HEADER, '0, '0, fmt_c, 16'(cur_w_nxt),
                          16'(cur_h_nxt), 5'(levels_nxt), depth_c, '0);
          n = n + 2'd1;
          phase_nxt = ktx_pkg::PH_SIZE; bc_nxt = '0; ws_nxt = '0;
        end

        if (do_lend) begin
          if (skip_r != 4'd0) begin
            skip_nxt = skip_r - 4'd1;
            phase_nxt = ktx_pkg::PH_SIZE; bc_nxt = '0; ws_nxt = '0;
          end else begin
            lidx_nxt = lidx_r + 4'd1;
            lv_c = levels_r;
            if (lv_c != '0) lv_c = lv_c - LW'(1);
            levels_nxt = lv_c;
            if (lv_c == '0) begin
              res_nxt[n] = mk(ktx_pkg::KIND_DONE, '0, '0, '0, '0, '0, '0, '0, '0);
              n = n + 2'd1;
              phase_nxt = ktx_pkg::PH_IDLE;
            end else begin
              phase_nxt = ktx_pkg::PH_SIZE; bc_nxt = '0; ws_nxt = '0;
            end
          end
        end

        cnt_nxt = n;
        idx_nxt = '0;
        if (n != 2'd0 && seq_nxt == ktx_pkg::SQ_READY) seq_nxt = ktx_pkg::SQ_EMIT;
      end
      ktx_pkg::SQ_MUL: begin
        mreq.start = 1'b1;
        seq_nxt = ktx_pkg::SQ_MULW;
      end
      ktx_pkg::SQ_MULW: begin
        if (mdone) begin
          idx_nxt = '0;
          cnt_nxt = 2'd1;
          seq_nxt = ktx_pkg::SQ_EMIT;
          if (ktx_pkg::PROD_W'(img_r) < mprod) begin
            res_nxt[0] = mk(ktx_pkg::KIND_ERROR, '0, '0, '0, '0, '0, '0, '0,
                            ktx_pkg::ERR_SIZE_SMALL);
            phase_nxt = ktx_pkg::PH_IDLE;
          end else begin
            phase_nxt = ktx_pkg::PH_DATA;
            cnt_nxt = 2'd0;
            seq_nxt = ktx_pkg::SQ_READY;
          end
        end
      end
      ktx_pkg::SQ_EMIT: begin
        if (out_free) begin
          out_data_nxt = res_r[idx_r];
          out_data_nxt.last = (idx_r == cnt_r - 2'd1);
          out_valid_nxt = 1'b1;
          idx_nxt = idx_r + 2'd1;
          if (idx_r == cnt_r - 2'd1) seq_nxt = ktx_pkg::SQ_READY;
        end
      end
      default: seq_nxt = ktx_pkg::SQ_READY;
    endcase
  end

  a_mul_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mdone |-> seq_r == ktx_pkg::SQ_MULW)
    else $error("multiplier finished outside its wait state");

  a_emit_idx: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r == ktx_pkg::SQ_EMIT |-> (cnt_r != 2'd0 && idx_r < cnt_r))
    else $error("result index out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("byte accepted while previous one still in work");

endmodule

FILE: bench/tb_ktx1_texture_stream_parser.sv
`timescale 1ns / 1ps

module tb_ktx1_texture_stream_parser;

  localparam int IDLE_LIMIT = 3000;
  localparam bit [7:0] ID_TAIL [8] = '{8'h20, 8'h31, 8'h31, 8'hBB, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
  localparam bit [31:0] GL_UNSIGNED_BYTE = 32'h1401;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  ktx_pkg::in_item_t in_data;
  ktx_pkg::out_item_t out_data;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [7:0] cfg_data;

  ktx1_texture_stream_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Parser shadow state.
  ktx_pkg::phase_t ph;
  bit [31:0] bcnt, wsh, typ, fmtw, ifmt, bfmt, cw, ch, lvls_left, kv_rem;
  bit [31:0] lvl_idx, img_rem, rpos, ridx, rgbp, skip_left, pad_left;
  bit swp, gray_alpha;
  bit [3:0] mip_skip;
  bit is_3d, is_array, is_cube, too_large;
  ktx_pkg::out_item_t step_results[$];
  ktx_pkg::out_item_t pending_results[$];

  int errs = 0;
  int idle_cycles = 0;
  bit quiet = 0;
  bit [7:0] file_bytes[$];
  bit file_swap;

  task automatic emit(bit [1:0] kind, bit [7:0] px, bit [31:0] fmt, bit [31:0] w,
                      bit [31:0] h, bit [31:0] mips, bit [31:0] depth, bit [3:0] err);
    ktx_pkg::out_item_t o;
    if (step_results.size() >= 3) return;
    o = '0;
    o.kind = kind;
    if (kind == ktx_pkg::KIND_PIXEL) begin
      o.pixel_byte = px;
      o.level = lvl_idx[3:0];
    end
    o.pixel_format = fmt[2:0];
    o.image_width = w[15:0];
    o.image_height = h[15:0];
    o.mip_count = mips[4:0];
    o.image_depth = depth[5:0];
    o.error_code = err;
    step_results.push_back(o);
  endtask

  task automatic fail_file(bit [3:0] code);
    emit(ktx_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 0, code);
    ph = ktx_pkg::PH_IDLE;
  endtask

  task automatic begin_word(ktx_pkg::phase_t p);
    ph = p;
    bcnt = 0;
    wsh = 0;
  endtask

  function automatic bit compressed();
    return typ == 0 && fmtw == 0;
  endfunction

  function automatic bit [31:0] bytes_per_pixel();
    case (bfmt)
      ktx_pkg::FMT_RGBA: return 4;
      ktx_pkg::FMT_RGB: return 3;
      ktx_pkg::FMT_LUM_ALPHA: return 2;
      default: return 1;
    endcase
  endfunction

  function automatic bit [31:0] mip_w();
    bit [31:0] v;
    v = cw >> lvl_idx;
    return v == 0 ? 1 : v;
  endfunction

  function automatic bit [31:0] mip_h();
    bit [31:0] v;
    v = ch >> lvl_idx;
    return v == 0 ? 1 : v;
  endfunction

  task automatic emit_header();
    bit [31:0] fmt, depth;
    if (compressed()) begin
      fmt = 4 + (ifmt - ktx_pkg::FMT_DXT1);
      depth = (ifmt == ktx_pkg::FMT_DXT1) ? 24 : 32;
    end else begin
      case (bfmt)
        ktx_pkg::FMT_RGBA: begin fmt = ktx_pkg::PF_RGBA; depth = 32; end
        ktx_pkg::FMT_RGB: begin fmt = ktx_pkg::PF_RGBA; depth = 24; end
        ktx_pkg::FMT_LUM: begin
          fmt = gray_alpha ? ktx_pkg::PF_ALPHA : ktx_pkg::PF_LUM;
          depth = 8;
        end
        ktx_pkg::FMT_ALPHA: begin fmt = ktx_pkg::PF_ALPHA; depth = 8; end
        default: begin fmt = ktx_pkg::PF_LUM_ALPHA; depth = 16; end
      endcase
    end
    emit(ktx_pkg::KIND_HEADER, 0, fmt, cw, ch, lvls_left, depth, 0);
    begin_word(ktx_pkg::PH_SIZE);
  endtask

  task automatic close_header(bit [31:0] kv);
    bit [3:0] err;
    bit [31:0] m, e, s;
    err = 0;
    if (is_3d) err = ktx_pkg::ERR_3D;
    else if (is_array) err = ktx_pkg::ERR_ARRAY;
    else if (is_cube) err = ktx_pkg::ERR_CUBE;
    else if (!too_large && cw == 0) err = ktx_pkg::ERR_ZERO_WIDTH;
    else if (too_large) err = ktx_pkg::ERR_TOO_LARGE;
    else if (compressed()) begin
      if (ifmt < ktx_pkg::FMT_DXT1 || ifmt > ktx_pkg::FMT_DXT5) err = ktx_pkg::ERR_COMP_FMT;
    end else if (bfmt < ktx_pkg::FMT_ALPHA || bfmt > ktx_pkg::FMT_LUM_ALPHA) begin
      err = ktx_pkg::ERR_UNCOMP_FMT;
    end
    if (err != 0) begin
      fail_file(err);
      return;
    end
    skip_left = 0;
    lvl_idx = 0;
    if (compressed() && lvls_left > 1 && mip_skip > 0) begin
      m = cw < ch ? cw : ch;
      e = 0;
      while (e < 31 && (32'd1 << e) < m) e++;
      if (e > 2) begin
        s = mip_skip;
        if (s > e - 2) s = e - 2;
        if (s > lvls_left - 1) s = lvls_left - 1;
        cw = cw >> s;
        if (cw == 0) cw = 1;
        ch = ch >> s;
        if (ch == 0) ch = 1;
        lvls_left -= s;
        skip_left = s;
      end
    end
    kv_rem = kv;
    if (kv == 0) emit_header();
    else ph = ktx_pkg::PH_KV;
  endtask

  task automatic store_word(bit [31:0] idx, bit [31:0] v);
    case (idx)
      0: typ = v;
      2: fmtw = v;
      3: ifmt = v;
      4: bfmt = v;
      5: begin
        if (v > 32'hFFFF) too_large = 1;
        cw = v & 32'hFFFF;
      end
      6: begin
        if (v == 0) v = 1;
        if (v > 32'hFFFF) too_large = 1;
        ch = v & 32'hFFFF;
      end
      7: if (v > 1) is_3d = 1;
      8: if (v > 1) is_array = 1;
      9: if (v > 1) is_cube = 1;
      10: begin
        if (v == 0) v = 1;
        if (v > ktx_pkg::MAX_LEVELS) v = ktx_pkg::MAX_LEVELS;
        lvls_left = v;
      end
      11: close_header(v);
      default: ;
    endcase
  endtask

  task automatic level_end();
    if (skip_left > 0) begin
      skip_left--;
      begin_word(ktx_pkg::PH_SIZE);
      return;
    end
    lvl_idx = (lvl_idx + 1) & 32'hF;
    if (lvls_left > 0) lvls_left--;
    if (lvls_left == 0) begin
      emit(ktx_pkg::KIND_DONE, 0, 0, 0, 0, 0, 0, 0);
      ph = ktx_pkg::PH_IDLE;
    end else begin_word(ktx_pkg::PH_SIZE);
  endtask

  task automatic after_data();
    if (pad_left > 0) ph = ktx_pkg::PH_PAD;
    else level_end();
  endtask

  task automatic start_level(bit [31:0] size);
    longint unsigned rb, stride;
    img_rem = size;
    pad_left = (0 - size) & 3;
    rpos = 0;
    ridx = 0;
    rgbp = 0;
    if (skip_left > 0) ph = ktx_pkg::PH_SKIP;
    else begin
      if (!compressed()) begin
        rb = longint'(mip_w()) * bytes_per_pixel();
        stride = (rb + 3) & ~longint'(3);
        if (longint'(size) < stride * mip_h()) begin
          fail_file(ktx_pkg::ERR_SIZE_SMALL);
          return;
        end
      end
      ph = ktx_pkg::PH_DATA;
    end
    if (size == 0) after_data();
  endtask

  task automatic data_byte(bit [7:0] b);
    bit [31:0] rb, stride, h;
    if (compressed()) begin
      emit(ktx_pkg::KIND_PIXEL, b, 0, 0, 0, 0, 0, 0);
      return;
    end
    rb = mip_w() * bytes_per_pixel();
    stride = (rb + 3) & ~32'd3;
    h = mip_h();
    if (ridx < h && rpos < rb) begin
      emit(ktx_pkg::KIND_PIXEL, b, 0, 0, 0, 0, 0, 0);
      if (bfmt == ktx_pkg::FMT_RGB) begin
        rgbp++;
        if (rgbp >= 3) begin
          emit(ktx_pkg::KIND_PIXEL, 8'hFF, 0, 0, 0, 0, 0, 0);
          rgbp = 0;
        end
      end
    end
    rpos++;
    if (rpos >= stride) begin
      rpos = 0;
      rgbp = 0;
      if (ridx < h) ridx++;
    end
  endtask

  task automatic parse_byte(bit [7:0] b, bit nf);
    bit [31:0] w;
    step_results.delete();
    if (nf) begin
      begin_word(ktx_pkg::PH_ID);
      {is_3d, is_array, is_cube, too_large} = '0;
      swp = 0;
      skip_left = 0;
      lvl_idx = 0;
    end
    case (ph)
      ktx_pkg::PH_ID: begin
        if (b != ID_TAIL[bcnt[2:0]]) fail_file(ktx_pkg::ERR_ID);
        else begin
          bcnt++;
          if (bcnt >= 8) begin_word(ktx_pkg::PH_ENDIAN);
        end
      end
      ktx_pkg::PH_ENDIAN, ktx_pkg::PH_HDR, ktx_pkg::PH_SIZE: begin
        wsh = (wsh >> 8) | (32'(b) << 24);
        bcnt++;
        if ((bcnt & 3) == 0) begin
          if (ph == ktx_pkg::PH_ENDIAN) begin
            if (wsh == ktx_pkg::ENDIAN_NATIVE) begin
              swp = 0; begin_word(ktx_pkg::PH_HDR);
            end else if (wsh == ktx_pkg::ENDIAN_SWAPPED) begin
              swp = 1; begin_word(ktx_pkg::PH_HDR);
            end else fail_file(ktx_pkg::ERR_ENDIAN);
          end else begin
            w = swp ? {wsh[7:0], wsh[15:8], wsh[23:16], wsh[31:24]} : wsh;
            if (ph == ktx_pkg::PH_HDR) store_word((bcnt >> 2) - 1, w);
            else start_level(w);
          end
        end
      end
      ktx_pkg::PH_KV: begin
        kv_rem--;
        if (kv_rem == 0) emit_header();
      end
      ktx_pkg::PH_SKIP, ktx_pkg::PH_DATA: begin
        if (ph == ktx_pkg::PH_DATA) data_byte(b);
        img_rem--;
        if (img_rem == 0) after_data();
      end
      ktx_pkg::PH_PAD: begin
        pad_left = (pad_left - 1) & 3;
        if (pad_left == 0) level_end();
      end
      default: ;
    endcase
    if (step_results.size() > 0) step_results[$].last = 1'b1;
  endtask

  task automatic gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return;
    if (r < 97) repeat ($urandom_range(1, 3)) @(negedge clk);
    else repeat ($urandom_range(20, 60)) @(negedge clk);
  endtask

  // Sends one byte, updates the shadow parser and leaves what it predicted in step_results.
  task automatic send_byte(bit [7:0] b, bit nf);
    gap();
    in_valid = 1'b1;
    in_data.in_byte = b;
    in_data.new_file = nf;
    do @(posedge clk); while (in_stall);
    parse_byte(b, nf);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_modeled(bit [7:0] b, bit nf);
    send_byte(b, nf);
    foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endtask

  task automatic write_reg(logic idx, bit [7:0] v);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    if (idx == ktx_pkg::CFG_GRAY_AS_ALPHA) gray_alpha = v[0];
    else mip_skip = v[3:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic put_word(bit [31:0] w);
    if (file_swap) begin
      file_bytes.push_back(w[31:24]); file_bytes.push_back(w[23:16]);
      file_bytes.push_back(w[15:8]); file_bytes.push_back(w[7:0]);
    end else begin
      file_bytes.push_back(w[7:0]); file_bytes.push_back(w[15:8]);
      file_bytes.push_back(w[23:16]); file_bytes.push_back(w[31:24]);
    end
  endtask

  task automatic build_file();
    bit comp;
    int fault, nlev, lw, lh, bpp, stride, size;
    bit [31:0] ifm, bfm, w, h, depth, arrays, faces, mips, kv;
    file_bytes.delete();
    file_swap = $urandom_range(0, 1);
    fault = $urandom_range(0, 15);
    comp = $urandom_range(0, 1);
    ifm = comp ? ktx_pkg::FMT_DXT1 + $urandom_range(0, 3) : ktx_pkg::FMT_RGBA;
    bfm = ktx_pkg::FMT_ALPHA + $urandom_range(0, 4);
    if (comp) begin
      w = 32'd1 << $urandom_range(0, 5);
      h = $urandom_range(0, 3) == 0 ? 0 : 32'd1 << $urandom_range(0, 5);
    end else begin
      w = $urandom_range(1, 6);
      h = $urandom_range(0, 5);
    end
    mips = $urandom_range(0, 15) == 0 ? $urandom_range(17, 40) : $urandom_range(0, 4);
    depth = $urandom_range(0, 1);
    arrays = $urandom_range(0, 1);
    faces = $urandom_range(0, 1);
    kv = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
    case (fault)
      0: depth = $urandom_range(2, 9);
      1: arrays = $urandom_range(2, 9);
      2: faces = 6;
      3: w = 0;
      4: if ($urandom_range(0, 1)) w = $urandom_range(65536, 200000); else h = 32'hFFFF_FFFF;
      5: begin
        if (comp) ifm = $urandom_range(0, 1) ? 32'h83F4 : 32'h83EF;
        else bfm = $urandom_range(0, 1) ? 32'h190B : 32'h1905;
      end
      default: ;
    endcase
    for (int i = 0; i < 4; i++) file_bytes.push_back(i + 1);
    if (file_swap) file_bytes.reverse();
    put_word(comp ? 0 : GL_UNSIGNED_BYTE);
    put_word(1);
    put_word(comp ? 0 : bfm);
    put_word(ifm);
    put_word(bfm);
    put_word(w);
    put_word(h);
    put_word(depth);
    put_word(arrays);
    put_word(faces);
    put_word(mips);
    put_word(kv);
    for (int i = 0; i < kv; i++) file_bytes.push_back($urandom_range(0, 255));
    nlev = mips == 0 ? 1 : (mips > ktx_pkg::MAX_LEVELS ? ktx_pkg::MAX_LEVELS : mips);
    if (fault > 5) begin
      bpp = bfm == ktx_pkg::FMT_RGBA ? 4 : bfm == ktx_pkg::FMT_RGB ? 3 :
            bfm == ktx_pkg::FMT_LUM_ALPHA ? 2 : 1;
      for (int i = 0; i < nlev; i++) begin
        lw = w >> i;
        lh = (h == 0 ? 1 : h) >> i;
        if (lw == 0) lw = 1;
        if (lh == 0) lh = 1;
        stride = (lw * bpp + 3) & ~3;
        if (comp) size = $urandom_range(0, 9);
        else if (fault == 6 && i == nlev - 1) size = stride * lh - $urandom_range(1, 3);
        else size = stride * lh + ($urandom_range(0, 2) == 0 ? $urandom_range(1, 5) : 0);
        put_word(size);
        for (int k = 0; k < size; k++) file_bytes.push_back($urandom_range(0, 255));
        for (int k = 0; k < ((4 - size % 4) % 4); k++) file_bytes.push_back($urandom_range(0, 255));
      end
    end
    if (fault == 7) file_bytes[$urandom_range(0, file_bytes.size() - 1)] ^= 8'h1 << $urandom_range(0, 7);
    if (fault == 8) file_bytes = file_bytes[0:$urandom_range(0, file_bytes.size() - 1)];
  endtask

  task automatic send_file();
    build_file();
    foreach (ID_TAIL[i]) send_modeled(ID_TAIL[i], i == 0);
    foreach (file_bytes[i]) send_modeled(file_bytes[i], 1'b0);
  endtask

  typedef struct {
    bit [7:0] b;
    bit nf;
    bit has_error;
    bit [3:0] code;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{8'h20, 1'b0, 1'b0, 4'd0},
    '{8'h55, 1'b1, 1'b1, ktx_pkg::ERR_ID},
    '{8'h20, 1'b1, 1'b0, 4'd0},
    '{8'h31, 1'b0, 1'b0, 4'd0},
    '{8'h31, 1'b0, 1'b0, 4'd0},
    '{8'hBB, 1'b0, 1'b0, 4'd0},
    '{8'h0D, 1'b0, 1'b0, 4'd0},
    '{8'h0A, 1'b0, 1'b0, 4'd0},
    '{8'h1A, 1'b0, 1'b0, 4'd0},
    '{8'h0A, 1'b0, 1'b0, 4'd0},
    '{8'h01, 1'b0, 1'b0, 4'd0},
    '{8'h02, 1'b0, 1'b0, 4'd0},
    '{8'h03, 1'b0, 1'b0, 4'd0},
    '{8'h05, 1'b0, 1'b1, ktx_pkg::ERR_ENDIAN},
    '{8'hFF, 1'b0, 1'b0, 4'd0},
    '{8'h20, 1'b1, 1'b0, 4'd0},
    '{8'h31, 1'b0, 1'b0, 4'd0},
    '{8'h31, 1'b0, 1'b0, 4'd0},
    '{8'h00, 1'b0, 1'b1, ktx_pkg::ERR_ID},
    '{8'h00, 1'b0, 1'b0, 4'd0}
  };

  initial begin
    ktx_pkg::out_item_t e;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = ktx_pkg::CFG_GRAY_AS_ALPHA;
    cfg_data = '0;
    gray_alpha = 0;
    mip_skip = 0;
    ph = ktx_pkg::PH_IDLE;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].b, dir_rows[i].nf);
      if (dir_rows[i].has_error) begin
        e = '0;
        e.kind = ktx_pkg::KIND_ERROR;
        e.error_code = dir_rows[i].code;
        e.last = 1'b1;
        pending_results.push_back(e);
      end
    end
    for (int p = 1; p < 5; p++) begin
      case (p)
        1: begin
          write_reg(ktx_pkg::CFG_GRAY_AS_ALPHA, 8'h01);
          write_reg(ktx_pkg::CFG_MIP_SKIP, 8'hFF);
        end
        2: begin
          write_reg(ktx_pkg::CFG_GRAY_AS_ALPHA, 8'hFE);
          write_reg(ktx_pkg::CFG_MIP_SKIP, 8'h02);
        end
        3: begin
          write_reg(ktx_pkg::CFG_GRAY_AS_ALPHA, 8'h01);
          write_reg(ktx_pkg::CFG_MIP_SKIP, 8'h00);
        end
        4: begin
          write_reg(ktx_pkg::CFG_GRAY_AS_ALPHA, 8'h00);
          write_reg(ktx_pkg::CFG_MIP_SKIP, 8'h01);
        end
        default: ;
      endcase
      quiet = (p == 3);
      repeat ($urandom_range(0, 2)) send_modeled($urandom_range(0, 255), 1'b0);
      send_file();
    end
    while (pending_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (errs == 0) $display("tb_ktx1_texture_stream_parser: PASS");
    else $display("tb_ktx1_texture_stream_parser: FAIL");
    $finish;
  end

  int stall_hold = 0;
  always @(negedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall <= $urandom_range(0, 2) == 0;
      stall_hold <= $urandom_range(0, 30) == 0 ? $urandom_range(20, 50) : $urandom_range(0, 3);
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    ktx_pkg::out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction, kind %0d", out_data.kind);
        errs++;
      end else begin
        e = pending_results.pop_front();
        check_field("kind", e.kind, out_data.kind);
        check_field("pixel_byte", e.pixel_byte, out_data.pixel_byte);
        check_field("level", e.level, out_data.level);
        check_field("pixel_format", e.pixel_format, out_data.pixel_format);
        check_field("image_width", e.image_width, out_data.image_width);
        check_field("image_height", e.image_height, out_data.image_height);
        check_field("mip_count", e.mip_count, out_data.mip_count);
        check_field("image_depth", e.image_depth, out_data.image_depth);
        check_field("error_code", e.error_code, out_data.error_code);
        check_field("last", e.last, out_data.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_ktx1_texture_stream_parser: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
